FILE: sv/s256h_pkg.sv
// Shared types, constants and round functions of the SHA-256 stream hasher.
package s256h_pkg;

  typedef logic [7:0][31:0] word8_t;

  // Control of the compression datapath, driven by the top-level sequencer.
  typedef struct packed {
    logic load;
    logic latch;
    logic step;
    logic sched;
  } core_ctrl_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Element 0 is the first hash word.
  localparam word8_t IV_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'd0, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

FILE: sv/s256h_if.sv
// Valid/ready channel interfaces for message bytes and digest words.
interface s256h_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last;

  modport source (output valid, data_byte, byte_valid, last, input ready);
  modport sink (input valid, data_byte, byte_valid, last, output ready);
endinterface

interface s256h_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  word_index;
  logic [31:0] digest_word;
  logic        last_word;

  modport source (output valid, word_index, digest_word, last_word, input ready);
  modport sink (input valid, word_index, digest_word, last_word, output ready);
endinterface

FILE: sv/sha256_stream_hasher.sv
// SHA-256 stream hasher top level: byte packing, block memory, padding and digest output.
// Message bytes are taken one per cycle while the hasher is idle. The byte that
// fills a 64-byte block starts a compression that holds off input: a load
// step, a latch step and an update step for each of 64 rounds, and a fold step
// into the hash; each round pulls four schedule words through the two read ports
// of the 16-word block memory. An item with last set adds padding, zero-fill
// and length writes and one or two compressions, after which the eight digest
// words are handed to a separate output register and the next message may
// start while they drain. A second digest waits only if the first has not been
// fully taken.
module sha256_stream_hasher import s256h_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  s256h_in_if.sink    msg_i,
  s256h_out_if.source dig_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLOAD  = 4'd1;
  localparam logic [3:0] S_RA     = 4'd2;
  localparam logic [3:0] S_RB     = 4'd3;
  localparam logic [3:0] S_CFIN   = 4'd4;
  localparam logic [3:0] S_PADW   = 4'd5;
  localparam logic [3:0] S_ZERO   = 4'd6;
  localparam logic [3:0] S_LEN_HI = 4'd7;
  localparam logic [3:0] S_LEN_LO = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  localparam logic [3:0] ADDR_LEN_HI = 4'd14;
  localparam logic [3:0] ADDR_LEN_LO = 4'd15;
  localparam logic [2:0] LAST_IDX    = 3'd7;
  localparam logic [5:0] LAST_POS    = 6'd63;
  localparam logic [5:0] LAST_ROUND  = 6'd63;

  logic [3:0]  state_q, state_d;
  logic [3:0]  ret_q, ret_d;
  logic [5:0]  pos_q, pos_d;
  logic [31:0] acc_q, acc_d;
  logic [63:0] bits_q, bits_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [4:0]  fi_q, fi_d;
  logic        two_q, two_d;
  word8_t      chain_q, chain_d;
  word8_t      dig_q, dig_d;
  logic [2:0]  idx_q, idx_d;
  logic        obusy_q, obusy_d;

  logic [31:0] blk_mem [16];
  logic        mem_we;
  logic [3:0]  mem_wa;
  logic [31:0] mem_wd;
  logic [3:0]  ra, rb;
  logic [31:0] rd_a_q, rd_b_q;

  core_ctrl_t  ctrl;
  logic [31:0] w_sched;
  word8_t      wv;

  logic        in_acc;
  logic [31:0] byte_word;
  logic [31:0] pad_word;
  logic [4:0]  lim;

  assign msg_i.ready = (state_q == S_IDLE);
  assign in_acc      = msg_i.valid && msg_i.ready;

  assign dig_o.valid       = obusy_q;
  assign dig_o.word_index  = idx_q;
  assign dig_o.digest_word = dig_q[0];
  assign dig_o.last_word   = (idx_q == LAST_IDX);

  s256h_core u_core (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .rnd_i  (rnd_q),
    .chain_i(chain_q),
    .rd_a_i (rd_a_q),
    .rd_b_i (rd_b_q),
    .w_o    (w_sched),
    .wv_o   (wv)
  );

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    pos_d   = pos_q;
    acc_d   = acc_q;
    bits_d  = bits_q;
    rnd_d   = rnd_q;
    fi_d    = fi_q;
    two_d   = two_q;
    chain_d = chain_q;
    dig_d   = dig_q;
    idx_d   = idx_q;
    obusy_d = obusy_q;
    mem_we  = 1'b0;
    mem_wa  = '0;
    mem_wd  = '0;
    ra      = '0;
    rb      = '0;
    ctrl    = '0;
    ctrl.sched = rnd_q[5] | rnd_q[4];

    // Bytes land big-endian; the lower bytes of a word stay zero until filled.
    byte_word = acc_q | ({24'd0, msg_i.data_byte} << {~pos_q[1:0], 3'b000});
    pad_word  = acc_q | ({24'd0, PAD_BYTE} << {~pos_q[1:0], 3'b000});
    lim       = two_q ? 5'd16 : 5'd14;

    if (obusy_q && dig_o.ready) begin
      dig_d = {32'd0, dig_q[7:1]};
      idx_d = idx_q + 3'd1;
      if (idx_q == LAST_IDX) begin
        obusy_d = 1'b0;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (msg_i.byte_valid) begin
            pos_d  = pos_q + 6'd1;
            bits_d = bits_q + 64'd8;
            if (pos_q[1:0] == 2'd3) begin
              mem_we = 1'b1;
              mem_wa = pos_q[5:2];
              mem_wd = byte_word;
              acc_d  = '0;
            end else begin
              acc_d = byte_word;
            end
          end
          if (msg_i.byte_valid && pos_q == LAST_POS) begin
            state_d = S_CLOAD;
            ret_d   = msg_i.last ? S_PADW : S_IDLE;
          end else if (msg_i.last) begin
            state_d = S_PADW;
          end
        end
      end
      S_CLOAD: begin
        ctrl.load = 1'b1;
        ra        = 4'd1;
        rb        = 4'd14;
        rnd_d     = '0;
        state_d   = S_RA;
      end
      S_RA: begin
        ctrl.latch = 1'b1;
        ra         = rnd_q[3:0];
        rb         = rnd_q[3:0] + 4'd9;
        state_d    = S_RB;
      end
      S_RB: begin
        ctrl.step = 1'b1;
        mem_we    = ctrl.sched;
        mem_wa    = rnd_q[3:0];
        mem_wd    = w_sched;
        // Reads for the next round; none of them hits the word written here.
        ra        = rnd_q[3:0] + 4'd2;
        rb        = rnd_q[3:0] + 4'd15;
        rnd_d     = rnd_q + 6'd1;
        state_d   = (rnd_q == LAST_ROUND) ? S_CFIN : S_RA;
      end
      S_CFIN: begin
        for (int i = 0; i < 8; i++) begin
          chain_d[i] = chain_q[i] + wv[i];
        end
        state_d = ret_q;
      end
      S_PADW: begin
        mem_we  = 1'b1;
        mem_wa  = pos_q[5:2];
        mem_wd  = pad_word;
        fi_d    = {1'b0, pos_q[5:2]} + 5'd1;
        // Fewer than eight bytes left after the pad byte: the length goes
        // into an extra block.
        two_d   = (pos_q[5:3] == 3'b111);
        state_d = S_ZERO;
      end
      S_ZERO: begin
        if (fi_q == lim) begin
          if (two_q) begin
            two_d   = 1'b0;
            fi_d    = '0;
            ret_d   = S_ZERO;
            state_d = S_CLOAD;
          end else begin
            state_d = S_LEN_HI;
          end
        end else begin
          mem_we = 1'b1;
          mem_wa = fi_q[3:0];
          mem_wd = '0;
          fi_d   = fi_q + 5'd1;
        end
      end
      S_LEN_HI: begin
        mem_we  = 1'b1;
        mem_wa  = ADDR_LEN_HI;
        mem_wd  = bits_q[63:32];
        state_d = S_LEN_LO;
      end
      S_LEN_LO: begin
        mem_we  = 1'b1;
        mem_wa  = ADDR_LEN_LO;
        mem_wd  = bits_q[31:0];
        ret_d   = S_DONE;
        state_d = S_CLOAD;
      end
      S_DONE: begin
        if (!obusy_q) begin
          dig_d   = chain_q;
          idx_d   = '0;
          obusy_d = 1'b1;
          chain_d = IV_INIT;
          bits_d  = '0;
          pos_d   = '0;
          acc_d   = '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      pos_q   <= '0;
      acc_q   <= '0;
      bits_q  <= '0;
      rnd_q   <= '0;
      fi_q    <= '0;
      two_q   <= 1'b0;
      chain_q <= IV_INIT;
      idx_q   <= '0;
      obusy_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      pos_q   <= pos_d;
      acc_q   <= acc_d;
      bits_q  <= bits_d;
      rnd_q   <= rnd_d;
      fi_q    <= fi_d;
      two_q   <= two_d;
      chain_q <= chain_d;
      idx_q   <= idx_d;
      obusy_q <= obusy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      blk_mem[mem_wa] <= mem_wd;
    end
    rd_a_q <= blk_mem[ra];
    rd_b_q <= blk_mem[rb];
  end

`ifndef SYNTHESIS
  a_last_word_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dig_o.valid && dig_o.ready && dig_o.last_word |=> !dig_o.valid)
    else $error("digest output still valid after its last word was taken");

  a_idle_round_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (rnd_q == 6'd0))
    else $error("round counter not cleared while idle");

  a_zero_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ZERO) |-> (fi_q <= lim))
    else $error("zero fill ran past its limit");

  a_full_block_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && msg_i.byte_valid && (pos_q == LAST_POS) |=> (state_q == S_CLOAD))
    else $error("full block did not start a compression");
`endif

endmodule

FILE: sv/s256h_core.sv
// Round datapath: working variables, schedule expansion and one round per step.
module s256h_core import s256h_pkg::*; (
  input  logic        clk_i,
  input  core_ctrl_t  ctrl_i,
  input  logic [5:0]  rnd_i,
  input  word8_t      chain_i,
  input  logic [31:0] rd_a_i,
  input  logic [31:0] rd_b_i,
  output logic [31:0] w_o,
  output word8_t      wv_o
);

  word8_t      wv_q, wv_d;
  logic [31:0] pre_q;
  logic [31:0] hk_q;
  logic [31:0] t1, t2;

  // In the latch cycle the read ports carry W[t-15] and W[t-2]; in the step
  // cycle they carry W[t-16] and W[t-7].
  always_comb begin
    w_o = ctrl_i.sched ? (rd_a_i + rd_b_i + pre_q) : rd_a_i;
    t1  = hk_q + bsig1(wv_q[4]) + choose(wv_q[4], wv_q[5], wv_q[6]) + w_o;
    t2  = bsig0(wv_q[0]) + majority(wv_q[0], wv_q[1], wv_q[2]);
    wv_d    = {wv_q[6:4], wv_q[3] + t1, wv_q[2:0], t1 + t2};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      wv_q <= chain_i;
    end else if (ctrl_i.step) begin
      wv_q <= wv_d;
    end
    if (ctrl_i.latch) begin
      pre_q <= ssig0(rd_a_i) + ssig1(rd_b_i);
      hk_q  <= wv_q[7] + K_TAB[rnd_i];
    end
  end

  assign wv_o = wv_q;

endmodule
